// ===== design/range_rule_classifier_assert.svh =====
// Assertion macros shared by the range rule classifier RTL.
`ifndef RANGE_RULE_CLASSIFIER_ASSERT_SVH
`define RANGE_RULE_CLASSIFIER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range rule classifier: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range rule classifier: next-cycle check failed");

`endif

// ===== design/rrc_pkg.sv =====
// Shared types and constants of the range rule classifier.
`default_nettype none

package rrc_pkg;

  // Fixed field widths of the words on the channels
  localparam int FIELD_W  = 16;
  localparam int INDEX_W  = 6;
  localparam int SPEND_W  = 2;
  localparam int WEIGHT_W = 16;
  localparam int OFFER_W  = 3;
  localparam int CFG_W    = 7;

  // Command codes of an input word
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // A rule spend code with this bit set accepts any query
  localparam int SPEND_ANY_BIT = 1;

  // -1.0 in Q8.8: weights must be strictly above this to win
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_FLOOR = -16'sd256;

  // Offer returned when no rule wins
  localparam logic [OFFER_W-1:0] FALLBACK_OFFER = 3'd4;

  // Input word
  typedef struct packed {
    logic                       cmd;
    logic [INDEX_W-1:0]         rule_index;
    logic [FIELD_W-1:0]         level_low;
    logic [FIELD_W-1:0]         level_high;
    logic [FIELD_W-1:0]         days_low;
    logic [FIELD_W-1:0]         days_high;
    logic [FIELD_W-1:0]         matches_low;
    logic [FIELD_W-1:0]         matches_high;
    logic [SPEND_W-1:0]         spend_match;
    logic signed [WEIGHT_W-1:0] weight;
  } rrc_in_word_t;

  // Result word
  typedef struct packed {
    logic [OFFER_W-1:0] offer_id;
    logic [INDEX_W-1:0] best_rule;
    logic               matched;
  } rrc_out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic write_rule;  // store the accepted word as a rule
    logic start;       // latch query, clear best, rewind read address
    logic issue;       // read one table entry, advance address
    logic load_out;    // move the best match into the output register
  } rrc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_empty;  // nothing to scan
    logic last_issue;  // current read address is the last one to scan
    logic out_free;    // output register can take a new word this cycle
  } rrc_status_t;

endpackage

`default_nettype wire

// ===== design/rrc_if.sv =====
// Valid/ready channel interfaces for input and result words.
`default_nettype none

interface rrc_in_if;
  import rrc_pkg::*;
  logic         valid;
  logic         ready;
  rrc_in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface rrc_out_if;
  import rrc_pkg::*;
  logic          valid;
  logic          ready;
  rrc_out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// ===== design/rrc_ctrl.sv =====
// Sequencing state machine of the range rule classifier.
`default_nettype none

module rrc_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  input  wire                      in_cmd,
  output logic                     in_ready,
  input  wire rrc_pkg::rrc_status_t status,
  output rrc_pkg::rrc_cmd_t         ctl
);
  import rrc_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  // Commands and next state
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_CLASSIFY) begin
            ctl.start  = 1'b1;
            state_next = SCAN;
          end else begin
            ctl.write_rule = 1'b1;
          end
        end
      end
      SCAN: begin
        if (status.scan_empty) begin
          state_next = FINISH;
        end else begin
          ctl.issue = 1'b1;
          if (status.last_issue) begin
            state_next = DRAIN;
          end
        end
      end
      // last read entry is being compared
      DRAIN: begin
        state_next = FINISH;
      end
      FINISH: begin
        if (status.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rrc_datapath.sv =====
// Rule table, scan compare and result register of the range rule classifier.
`default_nettype none

module rrc_datapath #(
  parameter int MAX_RULES   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_wr_en,
  input  wire [rrc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire rrc_pkg::rrc_in_word_t  word,
  input  wire rrc_pkg::rrc_cmd_t      ctl,
  output rrc_pkg::rrc_status_t        status,
  rrc_out_if.source                   reply
);
  import rrc_pkg::*;

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int VW = VALUE_WIDTH;

  // Rule table: low bound in the low half, high bound in the upper half
  logic [2*VW-1:0]         lvl_mem    [MAX_RULES];
  logic [2*VW-1:0]         days_mem   [MAX_RULES];
  logic [2*VW-1:0]         mat_mem    [MAX_RULES];
  logic [SPEND_W-1:0]      spend_mem  [MAX_RULES];
  logic signed [WEIGHT_W-1:0] weight_mem [MAX_RULES];

  logic [CFG_W-1:0]        rules_in_use;

  // Query latched at classify start
  logic [VW-1:0]           q_lvl;
  logic [VW-1:0]           q_days;
  logic [VW-1:0]           q_mat;
  logic [SPEND_W-1:0]      q_spend;

  // Scan read port
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           rd_idx;
  logic                    rd_valid;
  logic [2*VW-1:0]         rd_lvl;
  logic [2*VW-1:0]         rd_days;
  logic [2*VW-1:0]         rd_mat;
  logic [SPEND_W-1:0]      rd_spend;
  logic signed [WEIGHT_W-1:0] rd_weight;

  // Best match so far
  logic signed [WEIGHT_W-1:0] best_w;
  logic [AW-1:0]           best_i;
  logic                    found;

  // Output register
  logic                    out_valid;
  rrc_out_word_t           out_word;

  logic [31:0]             scan_cnt;
  logic [31:0]             best_ext;
  logic                    write_ok;
  logic                    hit;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
    end else if (cfg_wr_en) begin
      rules_in_use <= cfg_wr_data;
    end
  end

  // Scan length, clamped to the table depth
  assign scan_cnt = (32'(rules_in_use) > MAX_RULES) ? MAX_RULES : 32'(rules_in_use);

  assign status.scan_empty = (scan_cnt == 32'd0);
  assign status.last_issue = ((32'(rd_addr) + 32'd1) == scan_cnt);
  assign status.out_free   = !out_valid || reply.ready;

  // Table write; out-of-range indexes are dropped
  assign write_ok = ctl.write_rule && (32'(word.rule_index) < MAX_RULES);

  always_ff @(posedge clk) begin
    if (write_ok) begin
      lvl_mem[AW'(word.rule_index)]    <= {VW'(word.level_high), VW'(word.level_low)};
      days_mem[AW'(word.rule_index)]   <= {VW'(word.days_high), VW'(word.days_low)};
      mat_mem[AW'(word.rule_index)]    <= {VW'(word.matches_high), VW'(word.matches_low)};
      spend_mem[AW'(word.rule_index)]  <= word.spend_match;
      weight_mem[AW'(word.rule_index)] <= word.weight;
    end
  end

  // Registered table read, one entry per cycle
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rd_lvl    <= lvl_mem[rd_addr];
      rd_days   <= days_mem[rd_addr];
      rd_mat    <= mat_mem[rd_addr];
      rd_spend  <= spend_mem[rd_addr];
      rd_weight <= weight_mem[rd_addr];
      rd_idx    <= rd_addr;
    end
  end

  // Read address and read-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_addr  <= '0;
    end else begin
      rd_valid <= ctl.issue;
      if (ctl.start) begin
        rd_addr <= '0;
      end else if (ctl.issue) begin
        rd_addr <= rd_addr + AW'(1);
      end
    end
  end

  // Query latch
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_lvl   <= VW'(word.level_low);
      q_days  <= VW'(word.days_low);
      q_mat   <= VW'(word.matches_low);
      q_spend <= word.spend_match;
    end
  end

  // Match test of the entry just read; strict compare keeps the lower index on ties
  assign hit = rd_valid
            && (q_lvl  >= rd_lvl[VW-1:0])  && (q_lvl  <= rd_lvl[2*VW-1:VW])
            && (q_days >= rd_days[VW-1:0]) && (q_days <= rd_days[2*VW-1:VW])
            && (q_mat  >= rd_mat[VW-1:0])  && (q_mat  <= rd_mat[2*VW-1:VW])
            && (rd_spend[SPEND_ANY_BIT] || (rd_spend == q_spend))
            && (rd_weight > best_w);

  // Best match tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (hit) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best_w <= WEIGHT_FLOOR;
      best_i <= '0;
    end else if (hit) begin
      best_w <= rd_weight;
      best_i <= rd_idx;
    end
  end

  assign best_ext = 32'(best_i);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (reply.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_word.offer_id  <= found ? {1'b0, best_ext[1:0]} : FALLBACK_OFFER;
      out_word.best_rule <= found ? best_ext[INDEX_W-1:0] : '0;
      out_word.matched   <= found;
    end
  end

  assign reply.valid = out_valid;
  assign reply.word  = out_word;

endmodule

`default_nettype wire

// ===== design/range_rule_classifier.sv =====
// Top level of the range rule classifier: controller, datapath and checks.
// Write-rule word: no result; the controller stays idle, so the next word is taken the cycle after.
// Classify word: the scan reads N = min(rules_in_use, MAX_RULES) entries, the last compare drains,
// and the result is loaded once the output register is free; the next word is taken only then.
// The scan makes one registered rule-table read per cycle.
// Reset is synchronous, active high: clears control and rules_in_use; the table is not cleared.
`default_nettype none

module range_rule_classifier #(
  parameter int MAX_RULES   = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_wr_en,
  input  wire [rrc_pkg::CFG_W-1:0] cfg_wr_data,
  rrc_in_if.sink                   item,
  rrc_out_if.source                reply
);
  import rrc_pkg::*;

  rrc_cmd_t    ctl;
  rrc_status_t status;

  // Sequencer
  rrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_cmd   (item.word.cmd),
    .in_ready (item.ready),
    .status   (status),
    .ctl      (ctl)
  );

  // Table and compare datapath
  rrc_datapath #(
    .MAX_RULES   (MAX_RULES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .word        (item.word),
    .ctl         (ctl),
    .status      (status),
    .reply       (reply)
  );

`include "range_rule_classifier_assert.svh"

  // A classify word blocks further input while it scans
  `RRC_ASSERT_NEXT(a_busy_after_classify, clk, rst,
    item.valid && item.ready && (item.word.cmd == CMD_CLASSIFY), !item.ready)

  // A result is only loaded when the output register can take it
  `RRC_ASSERT_SAME(a_load_when_free, clk, rst, ctl.load_out, status.out_free)

  // No table read is issued for an empty scan
  `RRC_ASSERT_SAME(a_no_read_when_empty, clk, rst, ctl.issue, !status.scan_empty)

  // A result without a match carries the fallback offer and index zero
  `RRC_ASSERT_SAME(a_fallback_offer, clk, rst, reply.valid && !reply.word.matched,
    (reply.word.offer_id == FALLBACK_OFFER) && (reply.word.best_rule == '0))

endmodule

`default_nettype wire
